// ===== rtl/core/sbc_pkg.sv =====
// ----------------------------------------------------------------------------
// sbc_pkg: shared types and constants of the sprite blitter
// Register layout, reset values and the configuration bundle that the
// register block hands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sbc_pkg;

  localparam int unsigned CfgIdxBits  = 8;
  localparam int unsigned CfgDataBits = 16;

  localparam int unsigned PosBits  = 11;  // signed sprite position
  localparam int unsigned SizeBits = 10;  // sprite and surface sizes
  localparam int unsigned PixBits  = 8;

  localparam logic [CfgIdxBits-1:0] RegSpriteX      = 8'd0;
  localparam logic [CfgIdxBits-1:0] RegSpriteY      = 8'd1;
  localparam logic [CfgIdxBits-1:0] RegSpriteWidth  = 8'd2;
  localparam logic [CfgIdxBits-1:0] RegSpriteHeight = 8'd3;
  localparam logic [CfgIdxBits-1:0] RegSurfaceWidth = 8'd4;
  localparam logic [CfgIdxBits-1:0] RegSurfaceHeight = 8'd5;
  localparam logic [CfgIdxBits-1:0] RegKeyColour    = 8'd6;
  localparam logic [CfgIdxBits-1:0] RegMirror       = 8'd7;

  localparam logic [SizeBits-1:0] SpriteSizeReset   = 10'd1;
  localparam logic [SizeBits-1:0] SurfaceWidthReset = 10'd640;
  localparam logic [SizeBits-1:0] SurfaceHeightReset = 10'd480;
  localparam logic [PixBits-1:0]  KeyColourReset    = 8'd255;

  typedef struct packed {
    logic [PosBits-1:0]  sprite_x;
    logic [PosBits-1:0]  sprite_y;
    logic [SizeBits-1:0] sprite_width;
    logic [SizeBits-1:0] sprite_height;
    logic [SizeBits-1:0] surface_width;
    logic [SizeBits-1:0] surface_height;
    logic [PixBits-1:0]  key_colour;
    logic                mirror;
  } cfg_t;

  // A sprite size of zero behaves as one.
  function automatic logic [SizeBits-1:0] eff_size(input logic [SizeBits-1:0] sz);
    eff_size = (sz == '0) ? SizeBits'(1) : sz;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sbc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// sbc_cfg_regs: configuration register file
// Takes register writes from the configuration channel; unknown indices are
// dropped and data is cut to the register width.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_cfg_regs
  import sbc_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CfgIdxBits-1:0]  cfg_index_i,
  input  wire logic [CfgDataBits-1:0] cfg_data_i,
  output cfg_t                        cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        RegSpriteX:       cfg_d.sprite_x       = cfg_data_i[PosBits-1:0];
        RegSpriteY:       cfg_d.sprite_y       = cfg_data_i[PosBits-1:0];
        RegSpriteWidth:   cfg_d.sprite_width   = cfg_data_i[SizeBits-1:0];
        RegSpriteHeight:  cfg_d.sprite_height  = cfg_data_i[SizeBits-1:0];
        RegSurfaceWidth:  cfg_d.surface_width  = cfg_data_i[SizeBits-1:0];
        RegSurfaceHeight: cfg_d.surface_height = cfg_data_i[SizeBits-1:0];
        RegKeyColour:     cfg_d.key_colour     = cfg_data_i[PixBits-1:0];
        RegMirror:        cfg_d.mirror         = cfg_data_i[0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sprite_x       <= '0;
      cfg_q.sprite_y       <= '0;
      cfg_q.sprite_width   <= SpriteSizeReset;
      cfg_q.sprite_height  <= SpriteSizeReset;
      cfg_q.surface_width  <= SurfaceWidthReset;
      cfg_q.surface_height <= SurfaceHeightReset;
      cfg_q.key_colour     <= KeyColourReset;
      cfg_q.mirror         <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/sbc_pos_cnt.sv =====
// ----------------------------------------------------------------------------
// sbc_pos_cnt: column and row counters with the input register
// Tags each accepted pixel with its column, row and end-of-sprite flag and
// holds it until the result stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_pos_cnt
  import sbc_pkg::*;
#(
  parameter int unsigned COORD_BITS = 10
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cfg_t                  cfg_i,
  input  wire logic                  s_tvalid_i,
  output logic                       s_tready_o,
  input  wire logic [PixBits-1:0]    pixel_i,
  input  wire logic                  take_i,
  output logic                       vld_o,
  output logic [PixBits-1:0]         pixel_o,
  output logic [COORD_BITS-1:0]      col_o,
  output logic [COORD_BITS-1:0]      row_o,
  output logic                       last_o
);

  localparam int unsigned MW = (COORD_BITS > SizeBits) ? COORD_BITS : SizeBits;

  logic [COORD_BITS-1:0] col_cnt_q, col_cnt_d;
  logic [COORD_BITS-1:0] row_cnt_q, row_cnt_d;
  logic                  vld_q, vld_d;
  logic [PixBits-1:0]    pixel_q;
  logic [COORD_BITS-1:0] col_q, row_q;
  logic                  last_q;
  logic                  accept;
  logic [SizeBits-1:0]   w_m1, h_m1;
  logic                  row_end, sprite_end;

  assign s_tready_o = !vld_q || take_i;
  assign accept     = s_tvalid_i && s_tready_o;

  assign w_m1 = eff_size(cfg_i.sprite_width) - SizeBits'(1);
  assign h_m1 = eff_size(cfg_i.sprite_height) - SizeBits'(1);

  // Counters already past a shrunk size wrap at once, hence >= and not ==.
  assign row_end    = MW'(col_cnt_q) >= MW'(w_m1);
  assign sprite_end = row_end && (MW'(row_cnt_q) >= MW'(h_m1));

  always_comb begin
    col_cnt_d = col_cnt_q;
    row_cnt_d = row_cnt_q;
    if (accept) begin
      if (sprite_end) begin
        col_cnt_d = '0;
        row_cnt_d = '0;
      end else if (row_end) begin
        col_cnt_d = '0;
        row_cnt_d = row_cnt_q + COORD_BITS'(1);
      end else begin
        col_cnt_d = col_cnt_q + COORD_BITS'(1);
      end
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      vld_q     <= 1'b0;
    end else begin
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
      vld_q     <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pixel_q <= pixel_i;
      col_q   <= col_cnt_q;
      row_q   <= row_cnt_q;
      last_q  <= sprite_end;
    end
  end

  assign vld_o   = vld_q;
  assign pixel_o = pixel_q;
  assign col_o   = col_q;
  assign row_o   = row_q;
  assign last_o  = last_q;

endmodule

`default_nettype wire

// ===== rtl/core/sbc_clip_out.sv =====
// ----------------------------------------------------------------------------
// sbc_clip_out: destination coordinate, clipping and result register
// Forms the destination pixel position, clips it against the surface, applies
// the colour key and registers the result for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_clip_out
  import sbc_pkg::*;
#(
  parameter int unsigned COORD_BITS = 10
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cfg_t                  cfg_i,
  input  wire logic                  vld_i,
  output logic                       take_o,
  input  wire logic [PixBits-1:0]    pixel_i,
  input  wire logic [COORD_BITS-1:0] col_i,
  input  wire logic [COORD_BITS-1:0] row_i,
  input  wire logic                  last_i,
  output logic                       m_tvalid_o,
  input  wire logic                  m_tready_i,
  output logic                       write_o,
  output logic [SizeBits-1:0]        dest_x_o,
  output logic [SizeBits-1:0]        dest_y_o,
  output logic [PixBits-1:0]         colour_o,
  output logic                       last_o
);

  // Wide enough for the sprite position plus any column offset, with a sign.
  localparam int unsigned WB = ((COORD_BITS > SizeBits) ? COORD_BITS : SizeBits) + 3;

  logic [WB-1:0]       sx, sy, col_w, row_w, w_w, off, dx, dy;
  logic                vis_x, vis_y, wr;
  logic                out_vld_q, out_vld_d, out_rdy, load;
  logic                write_q, last_q;
  logic [SizeBits-1:0] dest_x_q, dest_y_q;
  logic [PixBits-1:0]  colour_q;

  assign sx    = {{(WB-PosBits){cfg_i.sprite_x[PosBits-1]}}, cfg_i.sprite_x};
  assign sy    = {{(WB-PosBits){cfg_i.sprite_y[PosBits-1]}}, cfg_i.sprite_y};
  assign col_w = {{(WB-COORD_BITS){1'b0}}, col_i};
  assign row_w = {{(WB-COORD_BITS){1'b0}}, row_i};
  assign w_w   = {{(WB-SizeBits){1'b0}}, eff_size(cfg_i.sprite_width)};

  // Mirrored columns run from the right edge; a column past a shrunk width
  // lands left of the sprite and is clipped like any other.
  assign off = cfg_i.mirror ? (w_w - WB'(1) - col_w) : col_w;
  assign dx  = sx + off;
  assign dy  = sy + row_w;

  assign vis_x = !dx[WB-1] && (dx < {{(WB-SizeBits){1'b0}}, cfg_i.surface_width});
  assign vis_y = !dy[WB-1] && (dy < {{(WB-SizeBits){1'b0}}, cfg_i.surface_height});
  assign wr    = vis_x && vis_y && (pixel_i != cfg_i.key_colour);

  assign out_rdy = !out_vld_q || m_tready_i;
  assign take_o  = out_rdy;
  assign load    = out_rdy && vld_i;

  assign out_vld_d = out_rdy ? vld_i : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      write_q  <= wr;
      dest_x_q <= wr ? dx[SizeBits-1:0] : '0;
      dest_y_q <= wr ? dy[SizeBits-1:0] : '0;
      colour_q <= pixel_i;
      last_q   <= last_i;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign write_o    = write_q;
  assign dest_x_o   = dest_x_q;
  assign dest_y_o   = dest_y_q;
  assign colour_o   = colour_q;
  assign last_o     = last_q;

endmodule

`default_nettype wire

// ===== rtl/core/sprite_blit_clip_colorkey_mirror_core.sv =====
// ----------------------------------------------------------------------------
// sprite_blit_clip_colorkey_mirror_core: colour-key sprite blitter
// Streams sprite pixels in, emits one clipped, keyed pixel write per pixel.
//
// Usage: configure position, sizes, surface bounds, key colour and mirror
// through the configuration channel while the block is idle; writes are
// always taken (cfg_ready_o is tied high). Sprite pixels then arrive in
// row-major order on the s_axis group, one 8-bit pixel per transfer. Each
// input transfer yields exactly one output transfer on the m_axis group:
// tuser says whether the pixel is written, tdata carries the destination
// column and row (zero when not written) and the colour, and tlast marks
// the final pixel of the sprite, after which the counters start again.
// An input transfer reaches its matching output transfer through the input
// register and then the result register. Throughput is one pixel per cycle
// while the receiver does not stall. When the receiver stalls the result
// register holds, the input register takes one more pixel only if it is
// empty, and s_axis_tready drops as soon as the input register is full.
// Reset clears the counters and both register stages and loads the register
// defaults (surface 640 by 480, key colour 255, sprite size one).
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_blit_clip_colorkey_mirror_core
  import sbc_pkg::*;
#(
  parameter int unsigned COORD_BITS = 10
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Configuration write channel.
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CfgIdxBits-1:0]  cfg_index_i,
  input  wire logic [CfgDataBits-1:0] cfg_data_i,
  // Pixel input stream.
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [7:0]             s_axis_tdata,   // [7:0] pixel
  // Pixel write stream.
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [31:0]                 m_axis_tdata,   // [9:0] dest_x, [19:10] dest_y,
                                                      // [27:20] colour, [31:28] zero
  output logic                        m_axis_tuser,   // [0] write
  output logic                        m_axis_tlast
);

  cfg_t                  cfg;
  logic                  stg_vld, stg_take, stg_last;
  logic [PixBits-1:0]    stg_pixel;
  logic [COORD_BITS-1:0] stg_col, stg_row;
  logic [SizeBits-1:0]   dest_x, dest_y;
  logic [PixBits-1:0]    colour;

  sbc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sbc_pos_cnt #(
    .COORD_BITS (COORD_BITS)
  ) u_pos_cnt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .pixel_i    (s_axis_tdata),
    .take_i     (stg_take),
    .vld_o      (stg_vld),
    .pixel_o    (stg_pixel),
    .col_o      (stg_col),
    .row_o      (stg_row),
    .last_o     (stg_last)
  );

  sbc_clip_out #(
    .COORD_BITS (COORD_BITS)
  ) u_clip_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .vld_i      (stg_vld),
    .take_o     (stg_take),
    .pixel_i    (stg_pixel),
    .col_i      (stg_col),
    .row_i      (stg_row),
    .last_i     (stg_last),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .write_o    (m_axis_tuser),
    .dest_x_o   (dest_x),
    .dest_y_o   (dest_y),
    .colour_o   (colour),
    .last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, colour, dest_y, dest_x};

  // A suppressed write never carries a coordinate.
  a_no_coord_without_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[19:0] == 20'd0))
    else $error("coordinate present on a suppressed write");

  // A result only appears after the input register held an item.
  a_result_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(stg_vld))
    else $error("result without a staged pixel");

  // With both stages full and the receiver stalled, no input is taken.
  a_full_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready && stg_vld) |-> !s_axis_tready)
    else $error("input accepted while pipeline is full");

endmodule

`default_nettype wire
